>>> rtl/kale_pkg.sv
// ----------------------------------------------------------------------------
// kale_pkg
// Shared types and constants of the keyed array list engine.
// ----------------------------------------------------------------------------
package kale_pkg;

  localparam int unsigned ENTRIES_DEFAULT  = 32;
  localparam int unsigned KEY_BITS_DEFAULT = 32;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned QTY_W   = 16;
  localparam int unsigned VAL_W   = 24;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned TOT_W   = 29;
  localparam int unsigned IN_W    = 80;
  localparam int unsigned OUT_W   = 120;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_FIND   = 3'd1,
    OP_COUNT  = 3'd2,
    OP_REMOVE = 3'd3,
    OP_SUM    = 3'd4,
    OP_MAX    = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  // The last member lands in the lowest bits.
  typedef struct packed {
    logic [VAL_W-1:0]  top_value;
    logic [QTY_W-1:0]  top_quantity;
    logic [KEY_W-1:0]  top_key;
    logic [TOT_W-1:0]  total_value;
    logic [POS_W-1:0]  match_count;
    logic [POS_W-1:0]  position;
    logic [STAT_W-1:0] status;
  } result_t;

endpackage

>>> rtl/keyed_array_list_engine.sv
// ----------------------------------------------------------------------------
// keyed_array_list_engine
// Ordered array-backed record list with insert, find, count, remove, sum, max.
// ----------------------------------------------------------------------------
// Records live in one synchronous memory read one entry per cycle. Insert
// writes the new record at the end of the list; find, count, remove, sum and
// max walk every stored entry through the single memory read port. Remove
// compacts in place by writing each surviving record back at the same or a
// lower index. One beat is worked on at a time; the result is held in an
// output register until it is taken.
module keyed_array_list_engine #(
  parameter int unsigned ENTRIES  = kale_pkg::ENTRIES_DEFAULT,
  parameter int unsigned KEY_BITS = kale_pkg::KEY_BITS_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // operation, item_key, item_quantity, item_value
  input  logic [kale_pkg::IN_W-1:0]  s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // status, position, match_count, total_value, top_key, top_quantity,
  // top_value
  output logic [kale_pkg::OUT_W-1:0] m_axis_tdata_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned SW = kale_pkg::VAL_W + CW;
  localparam int unsigned EW = KEY_BITS + kale_pkg::QTY_W + kale_pkg::VAL_W;

  typedef logic [EW-1:0] entry_t;

  entry_t mem_q [ENTRIES];
  entry_t rd_q;

  kale_pkg::state_e state_q, state_d;
  logic [2:0]          op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [kale_pkg::QTY_W-1:0] qty_q;
  logic [kale_pkg::VAL_W-1:0] val_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] chk_idx_q, chk_idx_d;
  logic          chk_vld_q, chk_vld_d;
  logic [CW-1:0] wr_idx_q, wr_idx_d;
  logic [CW-1:0] hits_q, hits_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [SW-1:0] sum_q, sum_d;
  entry_t        best_q, best_d;
  logic          out_vld_q, out_vld_d;
  kale_pkg::result_t res_q, res_d;

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;
  logic          rd_en;
  logic [KEY_BITS-1:0] rd_key;
  logic [kale_pkg::VAL_W-1:0] rd_val;
  logic          hit;

  assign s_axis_tready_o = (state_q == kale_pkg::S_IDLE) && !out_vld_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = kale_pkg::OUT_W'(res_q);

  assign rd_key = rd_q[EW-1 -: KEY_BITS];
  assign rd_val = rd_q[kale_pkg::VAL_W-1:0];
  assign hit    = (rd_key == key_q);
  assign rd_en  = (state_q == kale_pkg::S_WALK) && (rd_idx_q < cnt_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_axis_tdata_i[2:0];
      key_q <= KEY_BITS'(s_axis_tdata_i[34:3]);
      qty_q <= s_axis_tdata_i[35 +: kale_pkg::QTY_W];
      val_q <= s_axis_tdata_i[51 +: kale_pkg::VAL_W];
    end
    rd_idx_q  <= rd_idx_d;
    chk_idx_q <= chk_idx_d;
    wr_idx_q  <= wr_idx_d;
    hits_q    <= hits_d;
    pos_q     <= pos_d;
    sum_q     <= sum_d;
    best_q    <= best_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kale_pkg::S_IDLE;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      kale_pkg::S_IDLE: begin
        if (accept) begin
          state_d = kale_pkg::S_WALK;
        end
      end
      kale_pkg::S_WALK: begin
        if (!rd_en && !chk_vld_q) begin
          state_d = kale_pkg::S_DONE;
        end
      end
      kale_pkg::S_DONE: state_d = kale_pkg::S_IDLE;
      default:          state_d = kale_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d     = cnt_q;
    rd_idx_d  = rd_idx_q;
    chk_idx_d = chk_idx_q;
    chk_vld_d = 1'b0;
    wr_idx_d  = wr_idx_q;
    hits_d    = hits_q;
    pos_d     = pos_q;
    sum_d     = sum_q;
    best_d    = best_q;
    out_vld_d = out_vld_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_wa    = wr_idx_q[AW-1:0];
    mem_wd    = rd_q;
    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      kale_pkg::S_IDLE: begin
        rd_idx_d = '0;
        wr_idx_d = '0;
        hits_d   = '0;
        pos_d    = '0;
        sum_d    = '0;
      end
      kale_pkg::S_WALK: begin
        if (op_q == kale_pkg::OP_INSERT) begin
          rd_idx_d = cnt_q;
        end else if (rd_en) begin
          rd_idx_d  = rd_idx_q + CW'(1);
          chk_idx_d = rd_idx_q;
          chk_vld_d = 1'b1;
        end
        if (chk_vld_q) begin
          sum_d = sum_q + SW'(rd_val);
          if (chk_idx_q == '0 || rd_val > best_q[kale_pkg::VAL_W-1:0]) begin
            best_d = rd_q;
          end
          if (hit) begin
            hits_d = hits_q + CW'(1);
            if (hits_q == '0) begin
              pos_d = chk_idx_q + CW'(1);
            end
          end else begin
            wr_idx_d = wr_idx_q + CW'(1);
            if (op_q == kale_pkg::OP_REMOVE) begin
              mem_we = 1'b1;
            end
          end
        end
      end
      kale_pkg::S_DONE: begin
        res_d     = '0;
        out_vld_d = 1'b1;
        case (op_q)
          kale_pkg::OP_INSERT: begin
            if (cnt_q >= CW'(ENTRIES)) begin
              res_d.status = kale_pkg::ST_FULL;
            end else begin
              mem_we = 1'b1;
              mem_wa = cnt_q[AW-1:0];
              mem_wd = {key_q, qty_q, val_q};
              cnt_d  = cnt_q + CW'(1);
            end
          end
          kale_pkg::OP_FIND: begin
            if (hits_q == '0) begin
              res_d.status = kale_pkg::ST_NOTFOUND;
            end
            res_d.position = kale_pkg::POS_W'(pos_q);
          end
          kale_pkg::OP_COUNT: res_d.match_count = kale_pkg::POS_W'(hits_q);
          kale_pkg::OP_REMOVE: begin
            res_d.match_count = kale_pkg::POS_W'(hits_q);
            cnt_d = wr_idx_q;
          end
          kale_pkg::OP_SUM: begin
            if (sum_q > SW'({kale_pkg::TOT_W{1'b1}})) begin
              res_d.total_value = '1;
            end else begin
              res_d.total_value = kale_pkg::TOT_W'(sum_q);
            end
          end
          kale_pkg::OP_MAX: begin
            if (cnt_q == '0) begin
              res_d.status = kale_pkg::ST_EMPTY;
            end else begin
              res_d.top_key      = kale_pkg::KEY_W'(best_q[EW-1 -: KEY_BITS]);
              res_d.top_quantity = best_q[kale_pkg::VAL_W +: kale_pkg::QTY_W];
              res_d.top_value    = best_q[kale_pkg::VAL_W-1:0];
            end
          end
          default: res_d = '0;
        endcase
      end
      default: ;
    endcase
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(ENTRIES))
    else $error("entry count beyond capacity");
  a_wr_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kale_pkg::S_WALK && chk_vld_q) |-> wr_idx_q <= chk_idx_q)
    else $error("compaction write overtook read");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("second beat taken while busy");

endmodule

>>> tb/keyed_array_list_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_array_list_engine_checker
// Watches both stream channels, keeps a shadow record list and compares every
// result beat field by field against the predicted result.
// ----------------------------------------------------------------------------
module keyed_array_list_engine_checker (
  input  logic                       clk_i,
  input  logic                       s_axis_tvalid_i,
  input  logic                       s_axis_tready_i,
  input  logic [kale_pkg::IN_W-1:0]  s_axis_tdata_i,
  input  logic                       m_axis_tvalid_i,
  input  logic                       m_axis_tready_i,
  input  logic [kale_pkg::OUT_W-1:0] m_axis_tdata_i,
  output int unsigned                errors_o,
  output int unsigned                pending_o
);

  localparam int unsigned NREC = kale_pkg::ENTRIES_DEFAULT;

  typedef struct {
    logic [1:0]  status;
    logic [5:0]  position;
    logic [5:0]  match_count;
    logic [28:0] total_value;
    logic [31:0] top_key;
    logic [15:0] top_quantity;
    logic [23:0] top_value;
  } list_result_t;

  logic [kale_pkg::KEY_W-1:0] keys [NREC];
  logic [kale_pkg::QTY_W-1:0] qtys [NREC];
  logic [kale_pkg::VAL_W-1:0] vals [NREC];
  int unsigned      used = 0;
  list_result_t     expected_q [$];

  function automatic list_result_t apply_operation(logic [kale_pkg::IN_W-1:0] beat);
    list_result_t               r;
    logic [kale_pkg::OP_W-1:0]  op;
    logic [kale_pkg::KEY_W-1:0] k;
    int unsigned                w;
    int unsigned                best;
    longint unsigned            s;
    op = beat[2:0];
    k  = beat[34:3];
    r  = '{default: '0};
    w  = 0;
    s  = 0;
    best = 0;
    case (op)
      kale_pkg::OP_INSERT: begin
        if (used >= NREC) begin
          r.status = kale_pkg::ST_FULL;
        end else begin
          keys[used] = k;
          qtys[used] = beat[50:35];
          vals[used] = beat[74:51];
          used++;
        end
      end
      kale_pkg::OP_FIND: begin
        r.status = kale_pkg::ST_NOTFOUND;
        for (int i = 0; i < used; i++) begin
          if (keys[i] == k) begin
            r.status = kale_pkg::ST_OK;
            r.position = 6'(i + 1);
            break;
          end
        end
      end
      kale_pkg::OP_COUNT: begin
        for (int i = 0; i < used; i++) if (keys[i] == k) w++;
        r.match_count = 6'(w);
      end
      kale_pkg::OP_REMOVE: begin
        for (int i = 0; i < used; i++) begin
          if (keys[i] != k) begin
            keys[w] = keys[i];
            qtys[w] = qtys[i];
            vals[w] = vals[i];
            w++;
          end
        end
        r.match_count = 6'(used - w);
        used = w;
      end
      kale_pkg::OP_SUM: begin
        for (int i = 0; i < used; i++) s += vals[i];
        r.total_value = (s > 29'h1fffffff) ? 29'h1fffffff : s[28:0];
      end
      kale_pkg::OP_MAX: begin
        if (used == 0) begin
          r.status = kale_pkg::ST_EMPTY;
        end else begin
          for (int i = 1; i < used; i++) if (vals[i] > vals[best]) best = i;
          r.top_key = keys[best];
          r.top_quantity = qtys[best];
          r.top_value = vals[best];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  initial errors_o = 0;
  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    list_result_t e;
    if (m_axis_tvalid_i && m_axis_tready_i) begin
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation: 0x%0h", m_axis_tdata_i);
        errors_o++;
      end else begin
        e = expected_q.pop_front();
        compare_field("status", e.status, m_axis_tdata_i[1:0]);
        compare_field("position", e.position, m_axis_tdata_i[7:2]);
        compare_field("match_count", e.match_count, m_axis_tdata_i[13:8]);
        compare_field("total_value", e.total_value, m_axis_tdata_i[42:14]);
        compare_field("top_key", e.top_key, m_axis_tdata_i[74:43]);
        compare_field("top_quantity", e.top_quantity, m_axis_tdata_i[90:75]);
        compare_field("top_value", e.top_value, m_axis_tdata_i[114:91]);
      end
    end
    if (s_axis_tvalid_i && s_axis_tready_i) expected_q.push_back(apply_operation(s_axis_tdata_i));
  end

endmodule

>>> tb/keyed_array_list_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_array_list_engine_tb
// Drives directed and random operation beats with random gaps on both sides
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module keyed_array_list_engine_tb;

  localparam int unsigned N_RANDOM = 2000;
  localparam int unsigned LIMIT    = 3_000_000;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [kale_pkg::IN_W-1:0]  s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [kale_pkg::OUT_W-1:0] m_tdata;
  int unsigned                errors;
  int unsigned                pending;
  int unsigned                cycles = 0;
  logic [kale_pkg::KEY_W-1:0] key_pool [4];

  always #10 clk_i = ~clk_i;

  keyed_array_list_engine dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata)
  );

  keyed_array_list_engine_checker chk (
    .clk_i,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_i(m_tdata),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL keyed_array_list_engine");
      $finish;
    end
  end

  // Random back-pressure on the result side, with calm stretches.
  initial begin
    int unsigned stall;
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
    end
  end

  task automatic send_beat(logic [2:0] op, logic [31:0] k, logic [15:0] q, logic [23:0] v,
                           int unsigned gap);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, v, q, k, op};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    return ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 3)] : $urandom();
  endfunction

  initial begin
    logic [2:0]  op;
    int unsigned gap;
    int unsigned r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list cases, extremes, ties, fill to full, remove.
    send_beat(kale_pkg::OP_FIND, 32'h0, 16'h0, 24'h0, 0);
    send_beat(kale_pkg::OP_MAX, 32'h0, 16'h0, 24'h0, 0);
    send_beat(kale_pkg::OP_SUM, 32'h0, 16'h0, 24'h0, 0);
    send_beat(kale_pkg::OP_REMOVE, 32'h0, 16'h0, 24'h0, 0);
    send_beat(3'd6, 32'hffffffff, 16'hffff, 24'hffffff, 0);
    send_beat(3'd7, 32'hffffffff, 16'hffff, 24'hffffff, 0);
    send_beat(kale_pkg::OP_INSERT, 32'hffffffff, 16'hffff, 24'hffffff, 0);
    send_beat(kale_pkg::OP_INSERT, 32'h0, 16'h0, 24'h0, 0);
    send_beat(kale_pkg::OP_INSERT, 32'h5, 16'h1234, 24'hffffff, 0);
    send_beat(kale_pkg::OP_MAX, 32'h0, 16'h0, 24'h0, 0);
    send_beat(kale_pkg::OP_FIND, 32'h0, 16'h0, 24'h0, 0);
    send_beat(kale_pkg::OP_COUNT, 32'h7, 16'h0, 24'h0, 0);
    for (int i = 0; i < 30; i++) begin
      send_beat(kale_pkg::OP_INSERT, 32'(i % 2), 16'(i), 24'(24'hffffff - i), 0);
    end
    send_beat(kale_pkg::OP_SUM, 32'h0, 16'h0, 24'h0, 0);
    send_beat(kale_pkg::OP_COUNT, 32'h1, 16'h0, 24'h0, 0);
    send_beat(kale_pkg::OP_FIND, 32'h1, 16'h0, 24'h0, 0);
    send_beat(kale_pkg::OP_REMOVE, 32'h0, 16'h0, 24'h0, 0);
    send_beat(kale_pkg::OP_MAX, 32'h0, 16'h0, 24'h0, 0);
    send_beat(kale_pkg::OP_REMOVE, 32'h1, 16'h0, 24'h0, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 200 == 0) for (int j = 0; j < 4; j++) key_pool[j] = $urandom();
      r = $urandom_range(0, 99);
      op = (r < 40) ? kale_pkg::OP_INSERT : (r < 52) ? kale_pkg::OP_FIND :
           (r < 62) ? kale_pkg::OP_COUNT : (r < 74) ? kale_pkg::OP_REMOVE :
           (r < 84) ? kale_pkg::OP_SUM : (r < 97) ? kale_pkg::OP_MAX :
           3'($urandom_range(6, 7));
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      send_beat(op, pick_key(), 16'($urandom()), 24'($urandom()), gap);
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS keyed_array_list_engine");
    end else begin
      $display("FAIL keyed_array_list_engine");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/kale_pkg.sv
rtl/keyed_array_list_engine.sv
tb/keyed_array_list_engine_checker.sv
tb/keyed_array_list_engine_tb.sv
